// ===== rtl/imhq_pkg.sv =====
// Package: shared constants, types and codes for the indexed min-heap queue.
package imhq_pkg;

   localparam int CAPACITY_DEF     = 256;
   localparam int HANDLE_COUNT_DEF = 256;
   localparam int KEY_BITS_DEF     = 31;

   localparam int OP_W     = 2;
   localparam int HANDLE_W = 8;
   localparam int KEY_W    = 31;
   localparam int STATUS_W = 3;
   localparam int SIZE_W   = 9;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_UPDATE = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_FULL    = 3'd2,
      ST_ABSENT  = 3'd3,
      ST_PRESENT = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_POS_RD,     // position table read issued
      S_POS_CHK,    // position known, check it
      S_ROOT_RD,    // pop: read root
      S_ROOT_WT,
      S_LAST_RD,    // read last entry (for pop/remove)
      S_LAST_WT,
      S_FILL_WR,    // write moving entry into its slot (last entry into the hole for pop/remove)
      S_UP_RD,      // sift up: read parent
      S_UP_WT,
      S_UP_CMP,
      S_DN_RDL,     // sift down: read left child
      S_DN_RDR,     // read right child
      S_DN_WT,
      S_DN_CMP,
      S_SWAP_A,     // write neighbor entry to the mover's old slot
      S_SWAP_B,     // write moving entry to its new slot
      S_MIN_RD,
      S_MIN_WT,
      S_DONE
   } state_type;

endpackage

// ===== rtl/indexed_min_heap_queue.sv =====
// Top level: indexed binary min-heap priority queue with sequencer and memories.
//
// Usage:
//   Raise start with req_operation/req_handle/req_key while busy is low; the
//   transaction is accepted at that edge and busy goes high. When the work is
//   done the block pulses done for exactly one cycle with rsp_* holding the
//   result. busy is still high in the done cycle and drops in the cycle after it, so
//   the next start is accepted at the earliest in the cycle after the done cycle.
//   The receiver cannot stall; done is never held.
//   Operations: push, pop minimum, remove handle, update key of handle.
//   Each sift-up level reads the parent, compares, and makes two swap writes;
//   each sift-down level reads the left and the right child, makes two
//   compares and two swap writes. A 256-entry heap walks at most 8 levels.
//   The sequence is set by the single-port slot memory and the one shared key
//   comparator; the moving entry rides in registers, and both the neighbor
//   and the mover are written back on every level. One transaction runs at a time.
//   Reset: entry count clears and the handle-present flags clear at once
//   (flip-flops); the slot and position memories need no clearing pass.
module indexed_min_heap_queue #(
   parameter int CAPACITY     = imhq_pkg::CAPACITY_DEF,
   parameter int HANDLE_COUNT = imhq_pkg::HANDLE_COUNT_DEF,
   parameter int KEY_BITS     = imhq_pkg::KEY_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [imhq_pkg::OP_W-1:0]     req_operation,
   input  logic [imhq_pkg::HANDLE_W-1:0] req_handle,
   input  logic [imhq_pkg::KEY_W-1:0]    req_key,
   output logic                         done,
   output logic                         rsp_out_valid,
   output logic [imhq_pkg::HANDLE_W-1:0] rsp_out_handle,
   output logic [imhq_pkg::KEY_W-1:0]    rsp_out_key,
   output logic [imhq_pkg::STATUS_W-1:0] rsp_status,
   output logic [imhq_pkg::KEY_W-1:0]    rsp_min_key,
   output logic [imhq_pkg::SIZE_W-1:0]   rsp_heap_size,
   output logic                         rsp_is_empty
);
   import imhq_pkg::*;

   localparam int SLOT_W = $clog2(CAPACITY + 1);
   localparam int HIDX_W = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;

   // slot memory holds handle and key together, slots 0..CAPACITY
   logic [HANDLE_W-1:0] mem_h [0:CAPACITY];
   logic [KEY_BITS-1:0] mem_k [0:CAPACITY];
   logic [SLOT_W-1:0]   mem_pos [0:HANDLE_COUNT-1];
   logic [HANDLE_COUNT-1:0] present_ff, present_in;

   state_type state_ff, state_in;
   logic [SLOT_W-1:0]   count_ff, count_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;     // slot of moving entry
   logic [SLOT_W-1:0]   oth_ff, oth_in;     // slot of neighbor
   logic [HANDLE_W-1:0] mh_ff, mh_in;       // moving entry
   logic [KEY_BITS-1:0] mk_ff, mk_in;
   logic [HANDLE_W-1:0] bh_ff, bh_in;       // best neighbor
   logic [KEY_BITS-1:0] bk_ff, bk_in;
   logic                dn_ff, dn_in;       // 1: sift down phase
   logic                upd_ff, upd_in;     // 1: sift up moved something
   op_type              op_ff, op_in;
   logic [HANDLE_W-1:0] hd_ff, hd_in;
   logic [KEY_BITS-1:0] key_ff, key_in;

   logic                done_ff, done_in;
   logic                ov_ff, ov_in;
   logic [HANDLE_W-1:0] oh_ff, oh_in;
   logic [KEY_W-1:0]    ok_ff, ok_in;
   status_type          st_ff, st_in;
   logic [KEY_W-1:0]    mn_ff, mn_in;

   // slot memory port: one address, registered read
   logic [SLOT_W-1:0]   s_addr;
   logic                s_we;
   logic [HANDLE_W-1:0] s_wh;
   logic [KEY_BITS-1:0] s_wk;
   logic [HANDLE_W-1:0] s_rh_ff;
   logic [KEY_BITS-1:0] s_rk_ff;

   // position memory port
   logic [HIDX_W-1:0]   p_addr;
   logic                p_we;
   logic [SLOT_W-1:0]   p_wd;
   logic [SLOT_W-1:0]   p_rd_ff;

   always_ff @(posedge clock) begin
      if (s_we) begin
         mem_h[s_addr] <= s_wh;
         mem_k[s_addr] <= s_wk;
      end
      s_rh_ff <= mem_h[s_addr];
      s_rk_ff <= mem_k[s_addr];
      if (p_we) mem_pos[p_addr] <= p_wd;
      p_rd_ff <= mem_pos[p_addr];
   end

   // shared comparator
   logic [KEY_BITS-1:0] cmp_a, cmp_b;
   logic                cmp_lt;
   assign cmp_lt = cmp_a < cmp_b;

   logic                known;
   logic [HIDX_W-1:0]   req_hi, hd_hi, mh_hi, bh_hi;
   assign known  = 32'(req_handle) < 32'(HANDLE_COUNT);
   assign req_hi = HIDX_W'(req_handle);
   assign hd_hi  = HIDX_W'(hd_ff);
   assign mh_hi  = HIDX_W'(mh_ff);
   assign bh_hi  = HIDX_W'(bh_ff);

   logic [SLOT_W:0] lchild, rchild;
   assign lchild = {idx_ff, 1'b0};
   assign rchild = {idx_ff, 1'b1};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         present_ff <= '0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         present_ff <= present_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;  oth_ff <= oth_in;
      mh_ff  <= mh_in;   mk_ff  <= mk_in;
      bh_ff  <= bh_in;   bk_ff  <= bk_in;
      dn_ff  <= dn_in;   upd_ff <= upd_in;
      op_ff  <= op_in;   hd_ff  <= hd_in;   key_ff <= key_in;
      ov_ff  <= ov_in;   oh_ff  <= oh_in;   ok_ff  <= ok_in;
      st_ff  <= st_in;   mn_ff  <= mn_in;
   end

   always_comb begin
      state_in = state_ff;  count_in = count_ff;  present_in = present_ff;
      idx_in = idx_ff;  oth_in = oth_ff;  mh_in = mh_ff;  mk_in = mk_ff;
      bh_in = bh_ff;  bk_in = bk_ff;  dn_in = dn_ff;  upd_in = upd_ff;
      op_in = op_ff;  hd_in = hd_ff;  key_in = key_ff;
      ov_in = ov_ff;  oh_in = oh_ff;  ok_in = ok_ff;  st_in = st_ff;  mn_in = mn_ff;
      done_in = 1'b0;
      s_addr = idx_ff;  s_we = 1'b0;  s_wh = mh_ff;  s_wk = mk_ff;
      p_addr = hd_hi;   p_we = 1'b0;  p_wd = idx_ff;
      cmp_a = mk_ff;    cmp_b = s_rk_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = op_type'(req_operation);
               hd_in  = req_handle;
               key_in = KEY_BITS'(req_key);
               ov_in  = 1'b0;  oh_in = '0;  ok_in = '0;  st_in = ST_OK;
               dn_in  = 1'b0;  upd_in = 1'b0;
               p_addr = req_hi;
               case (op_type'(req_operation))
                  OP_PUSH: begin
                     if (!known) begin
                        st_in = ST_ABSENT;  state_in = S_MIN_RD;
                     end else if (present_ff[req_hi]) begin
                        st_in = ST_PRESENT; state_in = S_MIN_RD;
                     end else if (32'(count_ff) >= 32'(CAPACITY)) begin
                        st_in = ST_FULL;    state_in = S_MIN_RD;
                     end else begin
                        count_in = count_ff + 1'b1;
                        present_in[req_hi] = 1'b1;
                        idx_in = count_ff + 1'b1;
                        mh_in  = req_handle;
                        mk_in  = KEY_BITS'(req_key);
                        state_in = S_FILL_WR;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        st_in = ST_EMPTY;  state_in = S_MIN_RD;
                     end else begin
                        state_in = S_ROOT_RD;
                     end
                  end
                  default: begin
                     if (!known || !present_ff[req_hi]) begin
                        st_in = ST_ABSENT;  state_in = S_MIN_RD;
                     end else begin
                        state_in = S_POS_RD;
                     end
                  end
               endcase
            end
         end
         S_POS_RD: state_in = S_POS_CHK;
         S_POS_CHK: begin
            if (p_rd_ff == '0 || p_rd_ff > count_ff) begin
               st_in = ST_ABSENT;  state_in = S_MIN_RD;
            end else begin
               idx_in = p_rd_ff;
               if (op_ff == OP_REMOVE) begin
                  present_in[hd_hi] = 1'b0;
                  state_in = S_LAST_RD;
               end else begin
                  mh_in = hd_ff;  mk_in = key_ff;
                  state_in = S_FILL_WR;
               end
            end
         end
         S_ROOT_RD: begin
            s_addr = SLOT_W'(1);  idx_in = SLOT_W'(1);
            state_in = S_ROOT_WT;
         end
         S_ROOT_WT: begin
            ov_in = 1'b1;  oh_in = s_rh_ff;  ok_in = KEY_W'(s_rk_ff);
            present_in[HIDX_W'(s_rh_ff)] = 1'b0;
            state_in = S_LAST_RD;
         end
         S_LAST_RD: begin
            s_addr = count_ff;  state_in = S_LAST_WT;
         end
         S_LAST_WT: begin
            mh_in = s_rh_ff;  mk_in = s_rk_ff;
            count_in = count_ff - 1'b1;
            // hole was the last slot: nothing to refill
            if (idx_ff == count_ff) state_in = S_MIN_RD;
            else state_in = S_FILL_WR;
         end
         S_FILL_WR: begin
            s_we = 1'b1;  p_we = 1'b1;  p_addr = mh_hi;
            state_in = (op_ff == OP_POP) ? S_DN_RDL : S_UP_RD;
            dn_in = (op_ff == OP_POP);
            if (op_ff == OP_POP && count_ff <= SLOT_W'(1)) state_in = S_MIN_RD;
         end
         S_UP_RD: begin
            if (idx_ff == SLOT_W'(1)) begin
               dn_in = 1'b1;
               state_in = (op_ff == OP_PUSH || upd_ff) ? S_MIN_RD : S_DN_RDL;
            end else begin
               s_addr = idx_ff >> 1;  oth_in = idx_ff >> 1;
               state_in = S_UP_WT;
            end
         end
         S_UP_WT: begin
            bh_in = s_rh_ff;  bk_in = s_rk_ff;  state_in = S_UP_CMP;
         end
         S_UP_CMP: begin
            cmp_a = mk_ff;  cmp_b = bk_ff;
            if (cmp_lt) begin
               upd_in = 1'b1;  state_in = S_SWAP_A;
            end else begin
               dn_in = 1'b1;
               state_in = (op_ff == OP_PUSH || upd_ff) ? S_MIN_RD : S_DN_RDL;
            end
         end
         S_DN_RDL: begin
            if (32'(lchild) > 32'(count_ff)) state_in = S_MIN_RD;
            else begin
               s_addr = SLOT_W'(lchild);  state_in = S_DN_RDR;
            end
         end
         S_DN_RDR: begin
            // left child arrives and is latched as best; the next state keeps it only if smaller than the mover
            bh_in = s_rh_ff;  bk_in = s_rk_ff;  oth_in = SLOT_W'(lchild);
            s_addr = SLOT_W'(rchild);
            state_in = S_DN_WT;
         end
         S_DN_WT: begin
            // hold the right child on the read port for the next compare
            s_addr = SLOT_W'(rchild);
            cmp_a = bk_ff;  cmp_b = mk_ff;
            if (!cmp_lt) begin
               bk_in = mk_ff;  oth_in = idx_ff;
            end
            state_in = (32'(rchild) <= 32'(count_ff)) ? S_DN_CMP : S_SWAP_A;
            if (32'(rchild) > 32'(count_ff) && !cmp_lt) state_in = S_MIN_RD;
         end
         S_DN_CMP: begin
            cmp_a = s_rk_ff;  cmp_b = bk_ff;
            if (cmp_lt) begin
               bh_in = s_rh_ff;  bk_in = s_rk_ff;  oth_in = SLOT_W'(rchild);
               state_in = S_SWAP_A;
            end else if (oth_ff == idx_ff) begin
               state_in = S_MIN_RD;
            end else begin
               state_in = S_SWAP_A;
            end
         end
         S_SWAP_A: begin
            // neighbor drops into the mover's old slot
            s_addr = idx_ff;  s_we = 1'b1;  s_wh = bh_ff;  s_wk = bk_ff;
            p_we = 1'b1;  p_addr = bh_hi;  p_wd = idx_ff;
            idx_in = oth_ff;
            state_in = S_SWAP_B;
         end
         S_SWAP_B: begin
            s_we = 1'b1;  p_we = 1'b1;  p_addr = mh_hi;
            state_in = dn_ff ? S_DN_RDL : S_UP_RD;
         end
         S_MIN_RD: begin
            s_addr = SLOT_W'(1);  state_in = S_MIN_WT;
         end
         S_MIN_WT: begin
            mn_in = (count_ff == '0) ? {KEY_W{1'b1}} : KEY_W'(s_rk_ff);
            done_in = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // only the idle state takes a new transaction
   assign busy           = (state_ff != S_IDLE);
   assign done           = done_ff;
   assign rsp_out_valid  = ov_ff;
   assign rsp_out_handle = oh_ff;
   assign rsp_out_key    = ok_ff;
   assign rsp_status     = st_ff;
   assign rsp_min_key    = mn_ff;
   assign rsp_heap_size  = SIZE_W'(count_ff);
   assign rsp_is_empty   = (count_ff == '0);

   // entry count never exceeds capacity
   a_cap: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(CAPACITY)) else $error("heap over capacity");
   // a result strobe only after the sequencer finished
   a_done: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(state_ff) == S_MIN_WT) else $error("stray done");
   // failed operations return no entry
   a_fail: assert property (@(posedge clock) disable iff (reset)
      (done && rsp_status != ST_OK) |-> !rsp_out_valid) else $error("bad fail result");
endmodule
